// ===== hdl/gic_pkg.sv =====
// ---------------------------------------------------------------------------
// gic_pkg
// Shared types and codes for the GPIO interrupt controller.
// ---------------------------------------------------------------------------
package gic_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int GROUP_W = 3;
    localparam int SEL_W   = 3;
    localparam int IRQ_W   = 7;

    // request modes
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

    // register selects
    localparam logic [SEL_W-1:0] REG_STATUS = 3'd0;
    localparam logic [SEL_W-1:0] REG_ENABLE = 3'd1;
    localparam logic [SEL_W-1:0] REG_TYPE   = 3'd2;
    localparam logic [SEL_W-1:0] REG_LEVEL  = 3'd3;
    localparam logic [SEL_W-1:0] REG_FLIP   = 3'd4;
    localparam logic [SEL_W-1:0] REG_PIN    = 3'd5;

    // request broadcast to every group lane
    typedef struct packed {
        logic               start;
        logic [MODE_W-1:0]  mode;
        logic [GROUP_W-1:0] group;
        logic [SEL_W-1:0]   reg_select;
        logic [DATA_W-1:0]  data;
    } t_lane_req;

    // what one lane reports back to the merge stage
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              pending;
    } t_lane_rsp;

endpackage

// ===== hdl/gic_lane.sv =====
// ---------------------------------------------------------------------------
// gic_lane
// One interrupt group: register file, pin sampling and status latching.
// ---------------------------------------------------------------------------
module gic_lane #(
    parameter int LANE_ID        = 0,
    parameter int PINS_PER_GROUP = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gic_pkg::t_lane_req i_req,
    output gic_pkg::t_lane_rsp o_rsp
);

    localparam int PW = PINS_PER_GROUP;

    logic [PW-1:0] r_status, n_status;
    logic [PW-1:0] r_enable, n_enable;
    logic [PW-1:0] r_type,   n_type;
    logic [PW-1:0] r_level,  n_level;
    logic [PW-1:0] r_flip,   n_flip;
    logic [PW-1:0] r_last,   n_last;

    logic          w_sel;
    logic [PW-1:0] w_data;
    logic [PW-1:0] w_match;
    logic [PW-1:0] w_hit;
    logic [PW-1:0] w_rd;

    assign w_sel  = i_req.start && (i_req.group == gic_pkg::GROUP_W'(LANE_ID));
    assign w_data = i_req.data[PW-1:0];

    // edge pins need a change into the polarity, level pins only the match
    assign w_match = ~(w_data ^ r_level);
    assign w_hit   = r_enable & ((r_type & w_match) | (~r_type & w_match & (w_data ^ r_last)));

    always_comb begin
        n_status = r_status;
        n_enable = r_enable;
        n_type   = r_type;
        n_level  = r_level;
        n_flip   = r_flip;
        n_last   = r_last;
        if (w_sel) begin
            unique case (i_req.mode)
                gic_pkg::MODE_WRITE: begin
                    unique case (i_req.reg_select)
                        gic_pkg::REG_STATUS: n_status = r_status & ~w_data;
                        gic_pkg::REG_ENABLE: n_enable = w_data;
                        gic_pkg::REG_TYPE:   n_type   = w_data;
                        gic_pkg::REG_LEVEL:  n_level  = w_data;
                        gic_pkg::REG_FLIP:   n_flip   = w_data;
                        default: ;
                    endcase
                end
                gic_pkg::MODE_SAMPLE: begin
                    n_status = r_status | w_hit;
                    n_level  = r_level ^ (w_hit & r_flip);
                    n_last   = w_data;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_req.reg_select)
            gic_pkg::REG_STATUS: w_rd = r_status;
            gic_pkg::REG_ENABLE: w_rd = r_enable;
            gic_pkg::REG_TYPE:   w_rd = r_type;
            gic_pkg::REG_LEVEL:  w_rd = r_level;
            gic_pkg::REG_FLIP:   w_rd = r_flip;
            gic_pkg::REG_PIN:    w_rd = r_last;
            default:             w_rd = '0;
        endcase
    end

    assign o_rsp.rdata   = (w_sel && i_req.mode == gic_pkg::MODE_READ) ?
                           gic_pkg::DATA_W'(w_rd) : '0;
    assign o_rsp.pending = |n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_enable <= '0;
            r_type   <= '0;
            r_level  <= '0;
            r_flip   <= '0;
            r_last   <= '0;
        end else begin
            r_status <= n_status;
            r_enable <= n_enable;
            r_type   <= n_type;
            r_level  <= n_level;
            r_flip   <= n_flip;
            r_last   <= n_last;
        end
    end

endmodule

// ===== hdl/gic_merge.sv =====
// ---------------------------------------------------------------------------
// gic_merge
// Combines the lane responses into one result and registers it.
// ---------------------------------------------------------------------------
module gic_merge #(
    parameter int GROUPS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gic_pkg::t_lane_req           i_req,
    input  gic_pkg::t_lane_rsp           i_rsp [GROUPS],
    output logic                         o_strobe,
    output logic [gic_pkg::DATA_W-1:0]   o_read_data,
    output logic [gic_pkg::IRQ_W-1:0]    o_irq_lines,
    output logic                         o_access_error
);

    logic                       r_strobe;
    logic [gic_pkg::DATA_W-1:0] r_read_data, n_read_data;
    logic [gic_pkg::IRQ_W-1:0]  r_irq, n_irq;
    logic                       r_err, n_err;

    // only the addressed lane drives nonzero read data
    always_comb begin
        n_read_data = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_read_data = n_read_data | i_rsp[g].rdata;
        end
    end

    // groups past the irq width are not reported
    for (genvar g = 0; g < gic_pkg::IRQ_W; g++) begin : g_irq
        if (g < GROUPS) begin : g_live
            assign n_irq[g] = i_rsp[g].pending;
        end else begin : g_none
            assign n_irq[g] = 1'b0;
        end
    end

    // pin data is read-only, whatever the group
    assign n_err = (i_req.mode == gic_pkg::MODE_WRITE) &&
                   (i_req.reg_select == gic_pkg::REG_PIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe    <= 1'b0;
            r_read_data <= '0;
            r_irq       <= '0;
            r_err       <= 1'b0;
        end else begin
            r_strobe <= i_req.start;
            if (i_req.start) begin
                r_read_data <= n_read_data;
                r_irq       <= n_irq;
                r_err       <= n_err;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_read_data    = r_read_data;
    assign o_irq_lines    = r_irq;
    assign o_access_error = r_err;

endmodule

// ===== hdl/gpio_interrupt_controller.sv =====
// ---------------------------------------------------------------------------
// gpio_interrupt_controller
// GPIO interrupt controller: per-group enable, type, polarity, autoflip and
// write-1-to-clear status, with level and edge sensing of sampled pins.
// ---------------------------------------------------------------------------
// A request (register read, register write or pin sample) is taken on any
// clock edge with start high; busy is always low, so one request per cycle
// is sustained. Every group is a lane of its own that updates all its pins,
// and the merge stage registers the result, which shows on the outputs for
// one cycle with o_strobe high, in the cycle after the request was taken.
// The result cannot be held off, so capture it on the strobe.
// o_irq_lines reflects the status after that request's update.
module gpio_interrupt_controller #(
    parameter int GROUPS         = 7,
    parameter int PINS_PER_GROUP = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [gic_pkg::MODE_W-1:0]         i_mode,
    input  logic [gic_pkg::GROUP_W-1:0]        i_group,
    input  logic [gic_pkg::SEL_W-1:0]          i_reg_select,
    input  logic [gic_pkg::DATA_W-1:0]         i_data,
    output logic                               o_strobe,
    output logic [gic_pkg::DATA_W-1:0]         o_read_data,
    output logic [gic_pkg::IRQ_W-1:0]          o_irq_lines,
    output logic                               o_access_error
);

    gic_pkg::t_lane_req w_req;
    gic_pkg::t_lane_rsp w_rsp [GROUPS];

    assign busy = 1'b0;

    assign w_req.start      = start && !busy;
    assign w_req.mode       = i_mode;
    assign w_req.group      = i_group;
    assign w_req.reg_select = i_reg_select;
    assign w_req.data       = i_data;

    for (genvar g = 0; g < GROUPS; g++) begin : g_lane
        gic_lane #(
            .LANE_ID        (g),
            .PINS_PER_GROUP (PINS_PER_GROUP)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_req),
            .o_rsp   (w_rsp[g])
        );
    end

    gic_merge #(
        .GROUPS (GROUPS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_rsp          (w_rsp),
        .o_strobe       (o_strobe),
        .o_read_data    (o_read_data),
        .o_irq_lines    (o_irq_lines),
        .o_access_error (o_access_error)
    );

endmodule

// ===== hdl/gic_checker.sv =====
// ---------------------------------------------------------------------------
// gic_checker
// Port-level checks for the GPIO interrupt controller, bound to the top.
// ---------------------------------------------------------------------------
module gic_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [gic_pkg::MODE_W-1:0]    i_mode,
    input logic [gic_pkg::GROUP_W-1:0]   i_group,
    input logic [gic_pkg::SEL_W-1:0]     i_reg_select,
    input logic [gic_pkg::DATA_W-1:0]    i_data,
    input logic                          o_strobe,
    input logic [gic_pkg::DATA_W-1:0]    o_read_data,
    input logic [gic_pkg::IRQ_W-1:0]     o_irq_lines,
    input logic                          o_access_error
);

    logic w_acc;

    assign w_acc = i_rst_n && start && !busy;

    // exactly one result per request, in the cycle after it
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_strobe)
        else $error("request without result");

    a_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_acc) |=> !o_strobe)
        else $error("result without request");

    // writes to pin data flag an error and return zero read data
    a_pin_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == gic_pkg::MODE_WRITE && i_reg_select == gic_pkg::REG_PIN)
        |=> (o_access_error && o_read_data == '0))
        else $error("pin data write not flagged");

    // clearing every status bit of a group drops its irq line
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == gic_pkg::MODE_WRITE && i_reg_select == gic_pkg::REG_STATUS
         && i_data == '1 && i_group < 3'd7)
        |=> !o_irq_lines[$past(i_group)])
        else $error("irq line still set after full status clear");

    // the irq lines only move with a result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> $stable(o_irq_lines))
        else $error("irq lines changed without a result");

endmodule

bind gpio_interrupt_controller gic_checker u_gic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_mode         (i_mode),
    .i_group        (i_group),
    .i_reg_select   (i_reg_select),
    .i_data         (i_data),
    .o_strobe       (o_strobe),
    .o_read_data    (o_read_data),
    .o_irq_lines    (o_irq_lines),
    .o_access_error (o_access_error)
);
